### rtl/core/mctt_pkg.sv
// ---------------------------------------------------------------------------
// mctt_pkg: shared types and constants of the timer table
// Opcodes, status codes, sequencer states, per-timer flags and head events.
// ---------------------------------------------------------------------------
`default_nettype none
package mctt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int MAX_RESULTS    = 16;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_SET       = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_PAUSE     = 3'd3,
        OP_RESUME    = 3'd4,
        OP_ADD       = 3'd5,
        OP_QUERY     = 3'd6,
        OP_CLR_OWNER = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FIRED     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic used;
        logic paused;
        logic looping;
    } t_flags;

    typedef struct packed {
        logic fire;
        logic take;
        logic hit;
        logic freed;
    } t_event;

endpackage
`default_nettype wire

### rtl/core/mctt_cell.sv
// ---------------------------------------------------------------------------
// mctt_cell: one timer of the rotating timer chain
// Holds one timer and loads its neighbour's timer on every shift.
// ---------------------------------------------------------------------------
`default_nettype none
module mctt_cell #(
    parameter int TIME_WIDTH = mctt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire mctt_pkg::t_flags             i_flags,
    input  wire logic [7:0]                   i_owner,
    input  wire logic signed [TIME_WIDTH-1:0] i_dur,
    input  wire logic signed [TIME_WIDTH-1:0] i_rem,
    output mctt_pkg::t_flags                  o_flags,
    output logic [7:0]                        o_owner,
    output logic signed [TIME_WIDTH-1:0]      o_dur,
    output logic signed [TIME_WIDTH-1:0]      o_rem
);

    mctt_pkg::t_flags              r_flags;
    logic [7:0]                    r_owner;
    logic signed [TIME_WIDTH-1:0]  r_dur;
    logic signed [TIME_WIDTH-1:0]  r_rem;

    // Flags cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_shift) begin
            r_flags <= i_flags;
        end
    end

    // Payload of the timer
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_owner <= i_owner;
            r_dur   <= i_dur;
            r_rem   <= i_rem;
        end
    end

    assign o_flags = r_flags;
    assign o_owner = r_owner;
    assign o_dur   = r_dur;
    assign o_rem   = r_rem;

endmodule
`default_nettype wire

### rtl/core/mctt_head.sv
// ---------------------------------------------------------------------------
// mctt_head: command unit at the head of the chain
// Applies the current command to the timer passing the head.
// ---------------------------------------------------------------------------
`default_nettype none
module mctt_head #(
    parameter int TIME_WIDTH = mctt_pkg::TIME_WIDTH_DEF
) (
    input  wire mctt_pkg::t_op                i_op,
    input  wire logic                         i_match,
    input  wire logic                         i_first_free,
    input  wire logic [7:0]                   i_cmd_owner,
    input  wire logic                         i_cmd_loop,
    input  wire logic signed [TIME_WIDTH-1:0] i_amt,
    input  wire mctt_pkg::t_flags             i_flags,
    input  wire logic [7:0]                   i_owner,
    input  wire logic signed [TIME_WIDTH-1:0] i_dur,
    input  wire logic signed [TIME_WIDTH-1:0] i_rem,
    output mctt_pkg::t_flags                  o_flags,
    output logic [7:0]                        o_owner,
    output logic signed [TIME_WIDTH-1:0]      o_dur,
    output logic signed [TIME_WIDTH-1:0]      o_rem,
    output mctt_pkg::t_event                  o_ev,
    output logic signed [TIME_WIDTH-1:0]      o_rep
);

    localparam logic signed [TIME_WIDTH-1:0] TMAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
    localparam logic signed [TIME_WIDTH-1:0] TMIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    logic signed [TIME_WIDTH:0]   w_diff;
    logic signed [TIME_WIDTH:0]   w_sum;
    logic signed [TIME_WIDTH-1:0] w_sub_sat;
    logic signed [TIME_WIDTH-1:0] w_add_sat;
    logic signed [TIME_WIDTH-1:0] w_rem1;

    // Saturating subtract and add
    always_comb begin
        w_diff = (TIME_WIDTH+1)'(i_rem) - (TIME_WIDTH+1)'(i_amt);
        w_sum  = (TIME_WIDTH+1)'(i_rem) + (TIME_WIDTH+1)'(i_amt);
        if (w_diff[TIME_WIDTH] != w_diff[TIME_WIDTH-1]) begin
            w_sub_sat = w_diff[TIME_WIDTH] ? TMIN : TMAX;
        end else begin
            w_sub_sat = w_diff[TIME_WIDTH-1:0];
        end
        if (w_sum[TIME_WIDTH] != w_sum[TIME_WIDTH-1]) begin
            w_add_sat = w_sum[TIME_WIDTH] ? TMIN : TMAX;
        end else begin
            w_add_sat = w_sum[TIME_WIDTH-1:0];
        end
        w_rem1 = i_flags.paused ? i_rem : w_sub_sat;
    end

    // Apply the command to the head timer
    always_comb begin
        o_flags = i_flags;
        o_owner = i_owner;
        o_dur   = i_dur;
        o_rem   = i_rem;
        o_ev    = '0;
        o_rep   = i_rem;
        case (i_op)
            mctt_pkg::OP_TICK: begin
                if (i_flags.used) begin
                    o_rep = w_rem1;
                    o_rem = w_rem1;
                    if (w_rem1[TIME_WIDTH-1] || w_rem1 == '0) begin
                        o_ev.fire = 1'b1;
                        if (i_flags.looping) begin
                            o_rem = i_dur;
                        end else begin
                            o_flags.used   = 1'b0;
                            o_flags.paused = 1'b0;
                        end
                    end
                end
            end
            mctt_pkg::OP_SET: begin
                if (!i_flags.used && i_first_free) begin
                    o_ev.take       = 1'b1;
                    o_flags.used    = 1'b1;
                    o_flags.paused  = 1'b0;
                    o_flags.looping = i_cmd_loop;
                    o_owner         = i_cmd_owner;
                    o_dur           = i_amt;
                    o_rem           = i_amt;
                    o_rep           = i_amt;
                end
            end
            mctt_pkg::OP_CLR_OWNER: begin
                if (i_flags.used && i_owner == i_cmd_owner) begin
                    o_ev.freed     = 1'b1;
                    o_flags.used   = 1'b0;
                    o_flags.paused = 1'b0;
                end
            end
            default: begin
                if (i_match && i_flags.used) begin
                    o_ev.hit = 1'b1;
                    case (i_op)
                        mctt_pkg::OP_CLEAR: begin
                            o_flags.used   = 1'b0;
                            o_flags.paused = 1'b0;
                        end
                        mctt_pkg::OP_PAUSE:  o_flags.paused = 1'b1;
                        mctt_pkg::OP_RESUME: o_flags.paused = 1'b0;
                        mctt_pkg::OP_ADD:    o_rem = w_add_sat;
                        default:             o_rep = i_rem;
                    endcase
                end
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/multi_channel_timer_table.sv
// ---------------------------------------------------------------------------
// multi_channel_timer_table: table of countdown timers
// Rotating chain of timer cells with one command unit at its head.
// ---------------------------------------------------------------------------
// Every command keeps busy high through the scan and the done state: the
// timers rotate through the chain one cell a cycle and each passes the
// command unit once, then the done state forms the final result, which is
// registered and on the ports in the cycle in which busy is first low.
// Results come at most one a cycle on the strobe and cannot be held off; a
// tick reports fired timers lowest slot first, at most sixteen, the last one
// marked by o_last_result. A tick with no firing timer gives no result.
`default_nettype none
module multi_channel_timer_table #(
    parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = mctt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_opcode,
    input  wire logic [3:0]         i_timer_slot,
    input  wire logic [7:0]         i_owner_id,
    input  wire logic signed [31:0] i_time_amount,
    input  wire logic               i_loop_mode,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [3:0]              o_result_slot,
    output logic signed [31:0]      o_remaining,
    output logic                    o_last_result
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = (SW > 4) ? SW : 4;
    localparam int NW = $clog2(mctt_pkg::MAX_RESULTS + 1);
    localparam logic signed [63:0] TMAX64 = (64'sd1 <<< (TIME_WIDTH-1)) - 64'sd1;
    localparam logic signed [63:0] TMIN64 = -TMAX64 - 64'sd1;
    localparam logic signed [63:0] MAX32  = 64'sd2147483647;
    localparam logic signed [63:0] MIN32  = -64'sd2147483648;

    // Chain wiring
    mctt_pkg::t_flags             w_flags [NUM_TIMERS+1];
    logic [7:0]                   w_owner [NUM_TIMERS+1];
    logic signed [TIME_WIDTH-1:0] w_dur   [NUM_TIMERS+1];
    logic signed [TIME_WIDTH-1:0] w_rem   [NUM_TIMERS+1];
    mctt_pkg::t_event             w_ev;
    logic signed [TIME_WIDTH-1:0] w_rep;
    logic signed [63:0]           w_rep64;
    logic signed [31:0]           w_rep32;
    logic signed [63:0]           w_amt64;
    logic signed [TIME_WIDTH-1:0] w_amt;

    // Control and command registers
    mctt_pkg::t_state             r_state, n_state;
    logic [CW-1:0]                r_j, n_j;
    mctt_pkg::t_op                r_op;
    logic [3:0]                   r_slot;
    logic [7:0]                   r_owner;
    logic signed [TIME_WIDTH-1:0] r_amt;
    logic                         r_loop;
    logic                         r_found, n_found;
    logic [NW-1:0]                r_cnt, n_cnt;
    logic                         r_pv, n_pv;
    mctt_pkg::t_status            r_ps, n_ps;
    logic [3:0]                   r_pslot, n_pslot;
    logic signed [31:0]           r_prem, n_prem;
    logic                         n_strobe, n_last;
    mctt_pkg::t_status            n_status;
    logic [3:0]                   n_rslot;
    logic signed [31:0]           n_remaining;
    logic                         w_shift;
    logic                         w_accept;

    assign w_shift  = (r_state == mctt_pkg::S_SCAN);
    assign w_accept = start && !busy;
    assign busy     = (r_state != mctt_pkg::S_IDLE);

    // Saturate the command amount to the time width
    always_comb begin
        w_amt64 = 64'(i_time_amount);
        if (w_amt64 > TMAX64) begin
            w_amt64 = TMAX64;
        end else if (w_amt64 < TMIN64) begin
            w_amt64 = TMIN64;
        end
        w_amt = w_amt64[TIME_WIDTH-1:0];
    end

    // Saturate the reported time to 32 bits
    always_comb begin
        w_rep64 = 64'(w_rep);
        if (w_rep64 > MAX32) begin
            w_rep64 = MAX32;
        end else if (w_rep64 < MIN32) begin
            w_rep64 = MIN32;
        end
        w_rep32 = w_rep64[31:0];
    end

    // Chain of timer cells, the head output closing the ring
    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
        mctt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_flags (w_flags[k+1]),
            .i_owner (w_owner[k+1]),
            .i_dur   (w_dur[k+1]),
            .i_rem   (w_rem[k+1]),
            .o_flags (w_flags[k]),
            .o_owner (w_owner[k]),
            .o_dur   (w_dur[k]),
            .o_rem   (w_rem[k])
        );
    end

    mctt_head #(.TIME_WIDTH(TIME_WIDTH)) u_head (
        .i_op         (r_op),
        .i_match      (r_j == CW'(r_slot)),
        .i_first_free (!r_found),
        .i_cmd_owner  (r_owner),
        .i_cmd_loop   (r_loop),
        .i_amt        (r_amt),
        .i_flags      (w_flags[0]),
        .i_owner      (w_owner[0]),
        .i_dur        (w_dur[0]),
        .i_rem        (w_rem[0]),
        .o_flags      (w_flags[NUM_TIMERS]),
        .o_owner      (w_owner[NUM_TIMERS]),
        .o_dur        (w_dur[NUM_TIMERS]),
        .o_rem        (w_rem[NUM_TIMERS]),
        .o_ev         (w_ev),
        .o_rep        (w_rep)
    );

    // Sequencer state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mctt_pkg::S_IDLE;
            r_j      <= '0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_found  <= n_found;
            r_cnt    <= n_cnt;
            r_pv     <= n_pv;
            o_strobe <= n_strobe;
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= mctt_pkg::t_op'(i_opcode);
            r_slot  <= i_timer_slot;
            r_owner <= i_owner_id;
            r_amt   <= w_amt;
            r_loop  <= i_loop_mode;
        end
        r_ps          <= n_ps;
        r_pslot       <= n_pslot;
        r_prem        <= n_prem;
        o_status      <= n_status;
        o_result_slot <= n_rslot;
        o_remaining   <= n_remaining;
        o_last_result <= n_last;
    end

    // Next state, pending result and output
    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_found     = r_found;
        n_cnt       = r_cnt;
        n_pv        = r_pv;
        n_ps        = r_ps;
        n_pslot     = r_pslot;
        n_prem      = r_prem;
        n_strobe    = 1'b0;
        n_last      = 1'b0;
        n_status    = r_ps;
        n_rslot     = r_pslot;
        n_remaining = r_prem;
        case (r_state)
            mctt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = mctt_pkg::S_SCAN;
                    n_j     = '0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_pv    = (mctt_pkg::t_op'(i_opcode) != mctt_pkg::OP_TICK);
                    n_pslot = i_timer_slot;
                    n_prem  = '0;
                    case (mctt_pkg::t_op'(i_opcode))
                        mctt_pkg::OP_SET: begin
                            n_ps    = mctt_pkg::ST_FULL;
                            n_pslot = '0;
                        end
                        mctt_pkg::OP_CLR_OWNER: begin
                            n_ps    = mctt_pkg::ST_NOT_FOUND;
                            n_pslot = '0;
                        end
                        mctt_pkg::OP_QUERY: begin
                            n_ps   = mctt_pkg::ST_NOT_FOUND;
                            n_prem = -32'sd1;
                        end
                        default: n_ps = mctt_pkg::ST_NOT_FOUND;
                    endcase
                end
            end
            mctt_pkg::S_SCAN: begin
                n_j = r_j + CW'(1);
                if (r_j == CW'(NUM_TIMERS-1)) begin
                    n_state = mctt_pkg::S_DONE;
                end
                if (w_ev.fire && r_cnt < NW'(mctt_pkg::MAX_RESULTS)) begin
                    // Release the previous fire, hold this one back
                    n_strobe = r_pv;
                    n_pv     = 1'b1;
                    n_ps     = mctt_pkg::ST_FIRED;
                    n_pslot  = r_j[3:0];
                    n_prem   = w_rep32;
                    n_cnt    = r_cnt + NW'(1);
                end
                if (w_ev.take) begin
                    n_found = 1'b1;
                    n_ps    = mctt_pkg::ST_OK;
                    n_pslot = r_j[3:0];
                    n_prem  = w_rep32;
                end
                if (w_ev.freed) begin
                    n_ps = mctt_pkg::ST_OK;
                end
                if (w_ev.hit) begin
                    n_ps   = mctt_pkg::ST_OK;
                    n_prem = (r_op == mctt_pkg::OP_QUERY) ? w_rep32 : 32'sd0;
                end
            end
            mctt_pkg::S_DONE: begin
                n_state  = mctt_pkg::S_IDLE;
                n_strobe = r_pv;
                n_last   = 1'b1;
                n_pv     = 1'b0;
            end
            default: n_state = mctt_pkg::S_IDLE;
        endcase
    end

    // A final result is never followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_result |=> !o_strobe)
        else $error("result straight after final result");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Only fired timers come before the final result
    a_mid_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_result |-> o_status == mctt_pkg::ST_FIRED)
        else $error("non-final result that is not a fire");

endmodule
`default_nettype wire

### tb/multi_channel_timer_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multi_channel_timer_table_tb: self-checking bench for the timer table
// Drives a directed table of commands and then a random command stream,
// predicts every result with a behavioural timer table and compares each
// strobed result with the oldest expected one.
// ---------------------------------------------------------------------------
`default_nettype none
module multi_channel_timer_table_tb;

    localparam int NT        = 16;
    localparam int LIMIT_CYC = 400000;
    localparam int DRAIN_CYC = 40;

    typedef struct packed {
        mctt_pkg::t_status status;
        logic [3:0]        slot;
        logic [31:0]       rem;
        logic              last;
    } t_result;

    typedef struct {
        mctt_pkg::t_op op;
        logic [3:0]    slot;
        logic [7:0]    owner;
        logic [31:0]   amount;
        logic          loop_mode;
        logic          has_exp;
        t_result       exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [3:0]  i_timer_slot;
    logic [7:0]  i_owner_id;
    logic signed [31:0] i_time_amount;
    logic        i_loop_mode;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [3:0]  o_result_slot;
    logic signed [31:0] o_remaining;
    logic        o_last_result;

    // shadow copy of the timer table
    logic                tm_used  [NT];
    logic                tm_pause [NT];
    logic                tm_loop  [NT];
    logic [7:0]          tm_owner [NT];
    logic signed [31:0]  tm_dur   [NT];
    logic signed [31:0]  tm_rem   [NT];

    t_result pending_results[$];
    t_row    cmd_table[$];
    int      mismatches;
    int      results_seen;
    int      fires_seen;
    int      cycles;
    logic    gaps_on;

    multi_channel_timer_table dut (
        .i_clk, .i_rst_n, .start, .busy, .i_opcode, .i_timer_slot, .i_owner_id,
        .i_time_amount, .i_loop_mode, .o_strobe, .o_status, .o_result_slot,
        .o_remaining, .o_last_result
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // saturating signed 32-bit add
    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > 33'sd2147483647) return 32'h7fffffff;
        if (s < -33'sd2147483648) return 32'h80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] neg_sat(logic signed [31:0] b);
        return (b == 32'h80000000) ? 32'h7fffffff : -b;
    endfunction

    // compute the results of one command and advance the shadow table
    function automatic void predict_timers(mctt_pkg::t_op op, logic [3:0] slot,
                                           logic [7:0] owner,
                                           logic signed [31:0] amt, logic lm);
        t_result r;
        t_result q[$];
        logic    any;
        int      k;
        logic signed [31:0] d;
        q = {};
        case (op)
            mctt_pkg::OP_TICK: begin
                for (int i = 0; i < NT; i++) begin
                    if (!tm_used[i]) continue;
                    if (!tm_pause[i]) begin
                        // subtract with saturation, handling the minimum delta
                        if (amt == 32'h80000000)
                            d = (tm_rem[i] >= 0) ? 32'h7fffffff
                                : sat_sum(sat_sum(tm_rem[i], 32'h7fffffff), 1);
                        else
                            d = sat_sum(tm_rem[i], neg_sat(amt));
                        tm_rem[i] = d;
                    end
                    if (tm_rem[i] <= 0) begin
                        if (q.size() < mctt_pkg::MAX_RESULTS) begin
                            r = '{mctt_pkg::ST_FIRED, 4'(i), tm_rem[i], 1'b0};
                            q = {q, r};
                        end
                        if (tm_loop[i]) tm_rem[i] = tm_dur[i];
                        else begin
                            tm_used[i] = 1'b0;
                            tm_pause[i] = 1'b0;
                        end
                    end
                end
            end
            mctt_pkg::OP_SET: begin
                k = -1;
                for (int i = NT - 1; i >= 0; i--) if (!tm_used[i]) k = i;
                if (k >= 0) begin
                    tm_used[k] = 1'b1; tm_pause[k] = 1'b0; tm_loop[k] = lm;
                    tm_owner[k] = owner; tm_dur[k] = amt; tm_rem[k] = amt;
                    r = '{mctt_pkg::ST_OK, 4'(k), amt, 1'b0};
                end else r = '{mctt_pkg::ST_FULL, 4'd0, 32'd0, 1'b0};
                q = {q, r};
            end
            mctt_pkg::OP_CLR_OWNER: begin
                any = 1'b0;
                for (int i = 0; i < NT; i++)
                    if (tm_used[i] && tm_owner[i] == owner) begin
                        tm_used[i] = 1'b0; tm_pause[i] = 1'b0; any = 1'b1;
                    end
                r = '{mctt_pkg::t_status'(any ? mctt_pkg::ST_OK : mctt_pkg::ST_NOT_FOUND),
                      4'd0, 32'd0, 1'b0};
                q = {q, r};
            end
            default: begin
                if (!tm_used[slot]) begin
                    r = '{mctt_pkg::ST_NOT_FOUND, slot,
                          (op == mctt_pkg::OP_QUERY) ? 32'hffffffff : 32'd0, 1'b0};
                end else begin
                    r = '{mctt_pkg::ST_OK, slot, 32'd0, 1'b0};
                    case (op)
                        mctt_pkg::OP_CLEAR: begin
                            tm_used[slot] = 1'b0; tm_pause[slot] = 1'b0;
                        end
                        mctt_pkg::OP_PAUSE:  tm_pause[slot] = 1'b1;
                        mctt_pkg::OP_RESUME: tm_pause[slot] = 1'b0;
                        mctt_pkg::OP_ADD:    tm_rem[slot] = sat_sum(tm_rem[slot], amt);
                        default:             r.rem = tm_rem[slot];
                    endcase
                end
                q = {q, r};
            end
        endcase
        if (q.size() > 0) q[q.size() - 1].last = 1'b1;
        pending_results = {pending_results, q};
    endfunction

    // compare every strobed result with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            t_result got;
            t_result want;
            got = '{mctt_pkg::t_status'(o_status), o_result_slot, o_remaining,
                    o_last_result};
            results_seen++;
            if (o_status == mctt_pkg::ST_FIRED) fires_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d slot=%0d rem=%0d last=%0b",
                             o_status, o_result_slot, o_remaining, o_last_result);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d slot=%0d rem=%0d last=%0b,",
                                  " got st=%0d slot=%0d rem=%0d last=%0b"},
                                 want.status, want.slot, $signed(want.rem), want.last,
                                 o_status, o_result_slot, o_remaining, o_last_result);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // issue one command and wait for it to be taken
    task automatic issue_cmd(mctt_pkg::t_op op, logic [3:0] slot, logic [7:0] owner,
                             logic [31:0] amt, logic lm);
        int gap;
        while (busy) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_timer_slot  <= slot;
        i_owner_id    <= owner;
        i_time_amount <= amt;
        i_loop_mode   <= lm;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_timers(op, slot, owner, amt, lm);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void add_row(mctt_pkg::t_op op, logic [3:0] slot,
                                    logic [7:0] owner, logic [31:0] amt, logic lm,
                                    logic has_exp, t_result exp);
        t_row row;
        row = '{op, slot, owner, amt, lm, has_exp, exp};
        cmd_table = {cmd_table, row};
    endfunction

    // pick a random time, mostly small, sometimes at the extremes
    function automatic logic [31:0] rand_amount();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return $urandom();
            3:       return -$urandom_range(0, 20);
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    initial begin
        t_result       none;
        mctt_pkg::t_op op;
        int            n_issued;
        int            pick;
        none = '{mctt_pkg::ST_OK, 4'd0, 32'd0, 1'b0};
        mismatches = 0; results_seen = 0; fires_seen = 0; cycles = 0;
        gaps_on = 1'b1;
        i_rst_n <= 1'b0; start <= 1'b0; i_opcode <= mctt_pkg::OP_TICK;
        i_timer_slot <= '0; i_owner_id <= '0; i_time_amount <= '0;
        i_loop_mode <= 1'b0;
        for (int i = 0; i < NT; i++) begin
            tm_used[i] = 1'b0; tm_pause[i] = 1'b0; tm_loop[i] = 1'b0;
            tm_owner[i] = '0; tm_dur[i] = '0; tm_rem[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: empty table first, then extremes and each command
        add_row(mctt_pkg::OP_QUERY, 4'd0, 8'd0, 32'd0, 1'b0, 1'b1,
                '{mctt_pkg::ST_NOT_FOUND, 4'd0, 32'hffffffff, 1'b1});
        add_row(mctt_pkg::OP_CLEAR, 4'd15, 8'd0, 32'd0, 1'b0, 1'b1,
                '{mctt_pkg::ST_NOT_FOUND, 4'd15, 32'd0, 1'b1});
        add_row(mctt_pkg::OP_RESUME, 4'd3, 8'd0, 32'd0, 1'b0, 1'b1,
                '{mctt_pkg::ST_NOT_FOUND, 4'd3, 32'd0, 1'b1});
        add_row(mctt_pkg::OP_CLR_OWNER, 4'd0, 8'd255, 32'd0, 1'b0, 1'b1,
                '{mctt_pkg::ST_NOT_FOUND, 4'd0, 32'd0, 1'b1});
        add_row(mctt_pkg::OP_TICK, 4'd0, 8'd0, 32'd5, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_SET, 4'd0, 8'd255, 32'h7fffffff, 1'b0, 1'b1,
                '{mctt_pkg::ST_OK, 4'd0, 32'h7fffffff, 1'b1});
        add_row(mctt_pkg::OP_SET, 4'd0, 8'd0, 32'h80000000, 1'b1, 1'b1,
                '{mctt_pkg::ST_OK, 4'd1, 32'h80000000, 1'b1});
        add_row(mctt_pkg::OP_SET, 4'd0, 8'd7, 32'd3, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_SET, 4'd0, 8'd7, 32'd10, 1'b1, 1'b0, none);
        add_row(mctt_pkg::OP_PAUSE, 4'd2, 8'd0, 32'd0, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_TICK, 4'd0, 8'd0, 32'd4, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_ADD, 4'd0, 8'd0, 32'h7fffffff, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_ADD, 4'd2, 8'd0, 32'h80000000, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_RESUME, 4'd2, 8'd0, 32'd0, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_TICK, 4'd0, 8'd0, 32'h80000000, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_TICK, 4'd0, 8'd0, 32'h7fffffff, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_QUERY, 4'd3, 8'd0, 32'd0, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_CLEAR, 4'd1, 8'd0, 32'd0, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_RESUME, 4'd1, 8'd0, 32'd0, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_CLR_OWNER, 4'd0, 8'd7, 32'd0, 1'b0, 1'b0, none);
        for (int i = 0; i < 17; i++)
            add_row(mctt_pkg::OP_SET, 4'd0, 8'(i), 32'd1, 1'(i & 1), 1'b0, none);
        add_row(mctt_pkg::OP_TICK, 4'd0, 8'd0, 32'd1, 1'b0, 1'b0, none);
        add_row(mctt_pkg::OP_CLR_OWNER, 4'd0, 8'd3, 32'd0, 1'b0, 1'b0, none);

        foreach (cmd_table[i]) begin
            t_row row;
            row = cmd_table[i];
            issue_cmd(row.op, row.slot, row.owner, row.amount, row.loop_mode);
            if (row.has_exp) begin
                // typed-in expectation checked against the predictor too
                if (pending_results.size() == 0 || pending_results[$] !== row.exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: table expectation disagrees", i);
                end
            end
        end

        // random part: half sets and ticks over a busy table
        n_issued = 0;
        while (n_issued < 190) begin
            if (n_issued > 150) gaps_on = 1'b0;
            pick = $urandom_range(0, 19);
            if (pick < 5)       op = mctt_pkg::OP_SET;
            else if (pick < 10) op = mctt_pkg::OP_TICK;
            else                op = mctt_pkg::t_op'($urandom_range(2, 7));
            issue_cmd(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 7) == 0 ?
                      $urandom_range(0, 255) : $urandom_range(0, 3)),
                      (op == mctt_pkg::OP_TICK && $urandom_range(0, 3) != 0) ?
                          32'($urandom_range(0, 8)) : rand_amount(),
                      1'($urandom_range(0, 1)));
            n_issued++;
        end

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("covered %0d directed and %0d random commands, %0d results (%0d fires)",
                 cmd_table.size(), n_issued, results_seen, fires_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
